### hdl/acwld_pkg.sv
// ----------------------------------------------------------------------------
// acwld_pkg
// Shared widths, operation and status codes, and the item, result and
// alarm decision records of the alarm counter with late detection.
// ----------------------------------------------------------------------------
package acwld_pkg;

  localparam int DATA_W   = 32;
  localparam int OP_W     = 2;
  localparam int CH_W     = 2;
  localparam int FIRED_W  = 4;
  localparam int STATUS_W = 2;
  localparam int CFG_IDX_W = 1;

  localparam int DEF_CHANNELS   = 4;
  localparam int DEF_COUNT_BITS = 32;

  typedef enum logic [OP_W-1:0] {
    OP_TICK      = 2'd0,
    OP_SET_ALARM = 2'd1,
    OP_CANCEL    = 2'd2,
    OP_SET_TOP   = 2'd3
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK      = 2'd0,
    ST_INVALID = 2'd1,
    ST_BUSY    = 2'd2,
    ST_LATE    = 2'd3
  } status_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_GUARD_TICKS  = 1'd0,
    CFG_COUNT_ENABLE = 1'd1
  } cfg_idx_t;

  typedef struct packed {
    op_t              op;
    logic [CH_W-1:0]  ch;
    logic [DATA_W-1:0] ticks;
    logic             absolute;
    logic             expire_late;
    logic             keep_count;
    logic             reset_late;
    logic             top_ev_en;
  } item_t;

  typedef struct packed {
    status_t            status;
    logic [FIRED_W-1:0] fired;
    logic               top_ev;
    logic [DATA_W-1:0]  count;
  } res_t;

  // Outcome of a set-alarm request for the addressed channel.
  typedef struct packed {
    status_t status;
    logic    wr;     // compare value is written
    logic    arm;    // channel is armed after the write
    logic    fire;   // late alarm fires in this transfer
  } alarm_dec_t;

endpackage

### hdl/acwld_alarm_calc.sv
// ----------------------------------------------------------------------------
// acwld_alarm_calc
// Combinational evaluation of a set-alarm request: target value, distance
// from the current count and the late decision.
// ----------------------------------------------------------------------------
module acwld_alarm_calc
  import acwld_pkg::*;
#(
  parameter int CHANNELS   = DEF_CHANNELS,
  parameter int COUNT_BITS = DEF_COUNT_BITS
) (
  input  item_t                   item,
  input  logic [COUNT_BITS-1:0]   counter,
  input  logic [COUNT_BITS-1:0]   top,
  input  logic [DATA_W-1:0]       guard,
  input  logic [CHANNELS-1:0]     armed,
  output alarm_dec_t              dec,
  output logic [COUNT_BITS-1:0]   cmp_val
);

  localparam int CB = COUNT_BITS;

  logic [CB-1:0]     ticks_cb;
  logic [CB-1:0]     half;
  logic [CB-1:0]     max_rel;
  logic [CB-1:0]     val;
  logic [CB-1:0]     target;
  logic [CB-1:0]     diff;
  logic [CB:0]       sum;
  logic [CB:0]       sum_red;
  logic [DATA_W-1:0] top_ext;
  logic              ch_ok;
  logic              armed_ch;
  logic              invalid;
  logic              fire_late;
  logic              late;

  always_comb begin
    top_ext  = DATA_W'(top);
    ticks_cb = item.ticks[CB-1:0];
    half     = top >> 1;
    ch_ok    = ({1'b0, item.ch} < (CH_W+1)'(CHANNELS));
    armed_ch = 1'b0;
    for (int i = 0; i < CHANNELS; i++) begin
      if (item.ch == CH_W'(i)) begin
        armed_ch = armed[i];
      end
    end
    invalid = !ch_ok || (item.ticks > top_ext);

    // Relative target: now plus distance, reduced once by top + 1.
    sum     = {1'b0, counter} + {1'b0, ticks_cb};
    sum_red = sum - {1'b0, top} - (CB+1)'(1);

    if (item.absolute) begin
      max_rel   = (guard > top_ext) ? '0 : top - guard[CB-1:0];
      fire_late = item.expire_late;
      val       = ticks_cb;
    end else begin
      fire_late = (ticks_cb < half);
      max_rel   = fire_late ? half : top;
      val       = (sum > {1'b0, top}) ? sum_red[CB-1:0] : sum[CB-1:0];
    end

    // A target of zero is checked one step earlier, which wraps to top.
    target = (val == '0) ? top : val - CB'(1);
    diff   = (target >= counter) ? (target - counter)
                                 : (target + top + CB'(1) - counter);
    late   = (diff > max_rel);

    dec = '{status: ST_OK, wr: 1'b0, arm: 1'b0, fire: 1'b0};
    priority if (invalid) begin
      dec.status = ST_INVALID;
    end else if (armed_ch) begin
      dec.status = ST_BUSY;
    end else if (late) begin
      dec.wr     = 1'b1;
      dec.status = item.absolute ? ST_LATE : ST_OK;
      dec.fire   = fire_late;
    end else begin
      dec.wr  = 1'b1;
      dec.arm = 1'b1;
    end
    cmp_val = val;
  end

endmodule

### hdl/acwld_timer_core.sv
// ----------------------------------------------------------------------------
// acwld_timer_core
// Counter, top value and alarm channel state, updated once per registered
// item, with the result register.
// ----------------------------------------------------------------------------
module acwld_timer_core
  import acwld_pkg::*;
#(
  parameter int CHANNELS   = DEF_CHANNELS,
  parameter int COUNT_BITS = DEF_COUNT_BITS
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              item_vld,
  input  item_t             item,
  input  logic [DATA_W-1:0] guard,
  input  logic              count_en,
  output logic              res_vld,
  output res_t              res
);

  localparam int CB = COUNT_BITS;

  logic [CB-1:0]       cnt_r, cnt_nxt;
  logic [CB-1:0]       top_r, top_nxt;
  logic                top_irq_r, top_irq_nxt;
  logic [CHANNELS-1:0] armed_r, armed_nxt;
  logic [CB-1:0]       cmp_r [CHANNELS];
  logic [CB-1:0]       cmp_nxt [CHANNELS];
  logic                res_vld_r;
  res_t                res_r;

  alarm_dec_t          dec;
  logic [CB-1:0]       cmp_val;
  logic [CB-1:0]       cnt_inc;
  logic                wrap;
  logic                ch_ok;
  logic [CHANNELS-1:0] ch_sel;
  logic [CHANNELS-1:0] fired;
  status_t             status;
  logic                top_ev;

  acwld_alarm_calc #(
    .CHANNELS   (CHANNELS),
    .COUNT_BITS (COUNT_BITS)
  ) u_alarm_calc (
    .item    (item),
    .counter (cnt_r),
    .top     (top_r),
    .guard   (guard),
    .armed   (armed_r),
    .dec     (dec),
    .cmp_val (cmp_val)
  );

  always_comb begin
    cnt_nxt     = cnt_r;
    top_nxt     = top_r;
    top_irq_nxt = top_irq_r;
    armed_nxt   = armed_r;
    cmp_nxt     = cmp_r;
    status      = ST_OK;
    fired       = '0;
    top_ev      = 1'b0;

    // A counter at or above top wraps to zero on the next enabled tick.
    wrap    = (cnt_r >= top_r);
    cnt_inc = wrap ? '0 : cnt_r + CB'(1);
    ch_ok   = ({1'b0, item.ch} < (CH_W+1)'(CHANNELS));
    for (int i = 0; i < CHANNELS; i++) begin
      ch_sel[i] = (item.ch == CH_W'(i));
    end

    if (item_vld) begin
      unique case (item.op)
        OP_TICK: begin
          if (count_en) begin
            cnt_nxt = cnt_inc;
            top_ev  = wrap & top_irq_r;
            for (int i = 0; i < CHANNELS; i++) begin
              if (armed_r[i] && (cmp_r[i] == cnt_inc)) begin
                fired[i]     = 1'b1;
                armed_nxt[i] = 1'b0;
              end
            end
          end
        end
        OP_SET_ALARM: begin
          status = dec.status;
          for (int i = 0; i < CHANNELS; i++) begin
            if (ch_sel[i] && dec.wr) begin
              cmp_nxt[i]   = cmp_val;
              armed_nxt[i] = dec.arm;
              fired[i]     = dec.fire;
            end
          end
        end
        OP_CANCEL: begin
          if (!ch_ok) begin
            status = ST_INVALID;
          end else begin
            for (int i = 0; i < CHANNELS; i++) begin
              if (ch_sel[i]) begin
                armed_nxt[i] = 1'b0;
              end
            end
          end
        end
        OP_SET_TOP: begin
          if (|armed_r) begin
            status = ST_BUSY;
          end else begin
            top_nxt     = item.ticks[CB-1:0];
            top_irq_nxt = item.top_ev_en;
            if (!item.keep_count) begin
              cnt_nxt = '0;
            end else if (cnt_r >= item.ticks[CB-1:0]) begin
              status = ST_LATE;
              if (item.reset_late) begin
                cnt_nxt = '0;
              end
            end
          end
        end
        default: begin
          status = ST_OK;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r     <= '0;
      top_r     <= '1;
      top_irq_r <= 1'b0;
      armed_r   <= '0;
      res_vld_r <= 1'b0;
    end else begin
      cnt_r     <= cnt_nxt;
      top_r     <= top_nxt;
      top_irq_r <= top_irq_nxt;
      armed_r   <= armed_nxt;
      res_vld_r <= item_vld;
    end
  end

  // Compare values are only looked at while their channel is armed.
  always_ff @(posedge clk) begin
    cmp_r <= cmp_nxt;
    if (item_vld) begin
      res_r <= '{status: status, fired: FIRED_W'(fired), top_ev: top_ev,
                 count: DATA_W'(cnt_nxt)};
    end
  end

  assign res_vld = res_vld_r;
  assign res     = res_r;

  a_one_result: assert property (@(posedge clk) disable iff (!rst_n)
    item_vld |=> res_vld_r)
    else $error("registered item produced no result");

  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    !item_vld |=> !res_vld_r)
    else $error("result without an item");

  a_tick_fires_armed: assert property (@(posedge clk) disable iff (!rst_n)
    (item_vld && (item.op == OP_TICK)) |=>
      ((res_r.fired & FIRED_W'($past(armed_r))) == res_r.fired))
    else $error("tick fired a channel that was not armed");

  a_top_ev_tick_only: assert property (@(posedge clk) disable iff (!rst_n)
    (item_vld && (item.op != OP_TICK)) |=> !res_r.top_ev)
    else $error("top event outside a tick");

  a_top_held_armed: assert property (@(posedge clk) disable iff (!rst_n)
    (item_vld && (item.op == OP_SET_TOP) && (|armed_r)) |=> $stable(top_r))
    else $error("top changed while an alarm was armed");

endmodule

### hdl/alarm_counter_with_late_detect_top.sv
// ----------------------------------------------------------------------------
// alarm_counter_with_late_detect_top
// Wrapping up-counter with compare alarms and late detection, with an
// input register, configuration registers and the timer core.
// ----------------------------------------------------------------------------
// Each accepted item passes the input register and then the result register;
// out_valid then goes high for exactly one cycle.
// Throughput: one item per cycle; busy stays low, since the state update and
// result for each item complete in the cycle after the input register.
// Reset: synchronous on rst_n low; counter zero, top all ones, no alarm armed,
// guard register and count enable zero. No clearing pass is needed.
module alarm_counter_with_late_detect_top
  import acwld_pkg::*;
#(
  parameter int CHANNELS   = DEF_CHANNELS,
  parameter int COUNT_BITS = DEF_COUNT_BITS
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  output logic                 busy,
  input  logic [OP_W-1:0]      in_op,
  input  logic [CH_W-1:0]      in_channel,
  input  logic [DATA_W-1:0]    in_ticks,
  input  logic                 in_absolute,
  input  logic                 in_expire_when_late,
  input  logic                 in_keep_count,
  input  logic                 in_reset_when_late,
  input  logic                 in_top_event_enable,
  output logic                 out_valid,
  output logic [STATUS_W-1:0]  out_status,
  output logic [FIRED_W-1:0]   out_alarm_fired,
  output logic                 out_top_event,
  output logic [DATA_W-1:0]    out_count_now,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [DATA_W-1:0]    cfg_wdata
);

  logic              item_vld_r;
  item_t             item_r;
  logic [DATA_W-1:0] guard_r;
  logic              count_en_r;
  logic              res_vld;
  res_t              res;
  logic              accept;

  assign busy   = 1'b0;
  assign accept = start & ~busy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_vld_r <= 1'b0;
    end else begin
      item_vld_r <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item_r <= '{op: op_t'(in_op), ch: in_channel, ticks: in_ticks,
                  absolute: in_absolute, expire_late: in_expire_when_late,
                  keep_count: in_keep_count, reset_late: in_reset_when_late,
                  top_ev_en: in_top_event_enable};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      guard_r    <= '0;
      count_en_r <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_GUARD_TICKS:  guard_r    <= cfg_wdata;
        CFG_COUNT_ENABLE: count_en_r <= cfg_wdata[0];
        default:          guard_r    <= guard_r;
      endcase
    end
  end

  acwld_timer_core #(
    .CHANNELS   (CHANNELS),
    .COUNT_BITS (COUNT_BITS)
  ) u_timer_core (
    .clk      (clk),
    .rst_n    (rst_n),
    .item_vld (item_vld_r),
    .item     (item_r),
    .guard    (guard_r),
    .count_en (count_en_r),
    .res_vld  (res_vld),
    .res      (res)
  );

  assign out_valid       = res_vld;
  assign out_status      = res.status;
  assign out_alarm_fired = res.fired;
  assign out_top_event   = res.top_ev;
  assign out_count_now   = res.count;

endmodule
